/* src/iihf_pkg.sv */
// ---------------------------------------------------------------------------
// iihf_pkg: shared types and constants for the integral image Haar block
// state encoding, operation and status codes, register indexes and the
// per-corner weight table of the two-rectangle feature
// ---------------------------------------------------------------------------
package iihf_pkg;

  // default size of the integral store
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // fixed field widths
  localparam int REG_W  = 9;   // configuration register width
  localparam int POS_W  = 8;   // start row / start col
  localparam int SIZE_W = 9;   // window size
  localparam int PIX_W  = 8;
  localparam int RSUM_W = 16;  // running row sum
  localparam int IV_W   = 24;  // integral value
  localparam int FV_W   = 25;  // feature value
  localparam int ST_W   = 3;   // status
  localparam int CNT_W  = 3;   // corner counter, counts to NUM_CORNERS
  localparam int NUM_CORNERS = 6;
  localparam int REG_RESET   = 256;

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // configuration register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // status codes
  localparam logic [ST_W-1:0] STATUS_OK         = 3'd0;
  localparam logic [ST_W-1:0] STATUS_OUT_BOUNDS = 3'd1;
  localparam logic [ST_W-1:0] STATUS_ZERO_SIZE  = 3'd2;
  localparam logic [ST_W-1:0] STATUS_ODD_WIDTH  = 3'd3;
  localparam logic [ST_W-1:0] STATUS_INCOMPLETE = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_QUERY,
    ST_DONE
  } state_e;

  // corner column selector
  typedef enum logic [1:0] {
    COL_LEFT,
    COL_MID,
    COL_RIGHT
  } col_sel_e;

  // per-corner control of the shared adder
  typedef struct packed {
    logic     bottom;   // bottom row, else top row
    col_sel_e col;
    logic     dbl;      // weight two
    logic     neg;      // subtract
  } corner_t;

  // corners a..f: +a -2b +c -d +2e -f
  function automatic corner_t corner_info(logic [CNT_W-1:0] k);
    corner_t c;
    c = '{bottom: 1'b0, col: COL_LEFT, dbl: 1'b0, neg: 1'b0};
    unique case (k)
      3'd0: c = '{bottom: 1'b0, col: COL_LEFT,  dbl: 1'b0, neg: 1'b0};
      3'd1: c = '{bottom: 1'b0, col: COL_MID,   dbl: 1'b1, neg: 1'b1};
      3'd2: c = '{bottom: 1'b0, col: COL_RIGHT, dbl: 1'b0, neg: 1'b0};
      3'd3: c = '{bottom: 1'b1, col: COL_LEFT,  dbl: 1'b0, neg: 1'b1};
      3'd4: c = '{bottom: 1'b1, col: COL_MID,   dbl: 1'b1, neg: 1'b0};
      3'd5: c = '{bottom: 1'b1, col: COL_RIGHT, dbl: 1'b0, neg: 1'b1};
      default: c = '{bottom: 1'b0, col: COL_LEFT, dbl: 1'b0, neg: 1'b0};
    endcase
    return c;
  endfunction

  // clamp a register write to 1..maxv
  function automatic logic [REG_W-1:0] clamp_size(logic [REG_W-1:0] v, int maxv);
    logic [REG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = REG_W'(1);
    end else if (int'(v) > maxv) begin
      r = REG_W'(maxv);
    end
    return r;
  endfunction

endpackage

/* src/integral_image_haar_feature.sv */
// ---------------------------------------------------------------------------
// integral_image_haar_feature: summed-area image builder with Haar query
// loads pixels in raster order into an integral store and evaluates the
// two-rectangle vertical-split feature over a window from six corners
// ---------------------------------------------------------------------------
// One transaction at a time. A pixel load reads the entry above, adds and
// writes, then presents the result; a feature query reads six corners
// through the single store port, with the weighted sum built by one
// shared 25-bit adder, one corner a cycle. A query that fails a check
// goes straight to presenting its status. The store port is
// the limit: one read or one write per cycle. The input side takes a new
// transaction as soon as the sequencer is back in idle, even while the last
// result still waits in the output register. Writing either size register
// restarts loading at row 0, column 0. The store needs no clearing pass:
// a query only reads it once a whole image has been loaded.

module integral_image_haar_feature
  import iihf_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,

  // configuration write port
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [REG_W-1:0]         cfg_wdata_i,

  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     operation_i,
  input  logic [PIX_W-1:0]         pixel_i,
  input  logic [POS_W-1:0]         start_row_i,
  input  logic [POS_W-1:0]         start_col_i,
  input  logic [SIZE_W-1:0]        num_rows_i,
  input  logic [SIZE_W-1:0]        num_cols_i,

  // output channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [IV_W-1:0]          integral_value_o,
  output logic signed [FV_W-1:0]   feature_value_o,
  output logic [ST_W-1:0]          status_o
);

  // store address is {row, col}; col field is a power of two wide
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW = RW + CW;
  localparam int DEPTH = 2 ** AW;

  // integral store, single port, registered read
  logic [IV_W-1:0] mem [DEPTH];
  logic [IV_W-1:0] rd_q;
  logic [AW-1:0]   mem_addr;
  logic            mem_we;
  logic [IV_W-1:0] mem_wdata;

  // sequencer and load state
  state_e              state_q, state_d;
  logic [REG_W-1:0]    width_q, width_d;
  logic [REG_W-1:0]    height_q, height_d;
  logic [REG_W-1:0]    row_q, row_d;       // load position
  logic [REG_W-1:0]    col_q, col_d;
  logic [RSUM_W-1:0]   rsum_q, rsum_d;
  logic                complete_q, complete_d;
  logic                above_vld_q, above_vld_d;

  // query corners
  logic [REG_W-1:0]    top_q, top_d, bot_q, bot_d;
  logic                top_vld_q, top_vld_d;
  logic [REG_W-1:0]    cl_q, cl_d, cm_q, cm_d, cr_q, cr_d;
  logic                cl_vld_q, cl_vld_d;
  logic [CNT_W-1:0]    k_q, k_d;
  logic                cv_q, cv_d;         // corner read last cycle is real
  logic [FV_W-1:0]     acc_q, acc_d;
  logic                is_query_q, is_query_d;
  logic [ST_W-1:0]     qstat_q, qstat_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [IV_W-1:0]     ival_q, ival_d;
  logic [FV_W-1:0]     fval_q, fval_d;
  logic [ST_W-1:0]     ostat_q, ostat_d;

  // shared adder
  logic [FV_W-1:0]     alu_a, alu_b, alu_sum;
  logic                alu_neg;

  assign alu_sum = alu_a + (alu_neg ? ~alu_b : alu_b) + FV_W'(alu_neg);

  function automatic logic [AW-1:0] addr_of(logic [REG_W-1:0] r, logic [REG_W-1:0] c);
    return {RW'(r), CW'(c)};
  endfunction

  logic in_accept;
  logic out_free;
  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;

  // window checks and corner positions, worked out at acceptance
  logic [REG_W:0]    row_end, col_end;
  logic [REG_W:0]    cm_sum, cr_sum;
  logic [ST_W-1:0]   chk_stat;

  assign row_end = {2'b00, start_row_i} + {1'b0, num_rows_i};
  assign col_end = {2'b00, start_col_i} + {1'b0, num_cols_i};
  assign cm_sum  = {2'b00, start_col_i} + {2'b00, num_cols_i[SIZE_W-1:1]} - (REG_W+1)'(1);
  assign cr_sum  = col_end - (REG_W+1)'(1);

  always_comb begin
    if (row_end > {1'b0, height_q} || col_end > {1'b0, width_q}) begin
      chk_stat = STATUS_OUT_BOUNDS;
    end else if (num_rows_i == '0 || num_cols_i == '0) begin
      chk_stat = STATUS_ZERO_SIZE;
    end else if (num_cols_i[0]) begin
      chk_stat = STATUS_ODD_WIDTH;
    end else if (!complete_q) begin
      chk_stat = STATUS_INCOMPLETE;
    end else begin
      chk_stat = STATUS_OK;
    end
  end

  // load position after a possible restart on a finished image
  logic [REG_W-1:0]  eff_row, eff_col;
  logic [RSUM_W-1:0] eff_rsum;
  assign eff_row  = complete_q ? '0 : row_q;
  assign eff_col  = complete_q ? '0 : col_q;
  assign eff_rsum = complete_q ? '0 : rsum_q;

  // current corner of the query walk
  corner_t          cinfo, pinfo;
  logic [REG_W-1:0] c_row, c_col;
  logic             c_vld;

  always_comb begin
    cinfo = corner_info(k_q);
    pinfo = corner_info(k_q - CNT_W'(1));
    c_row = cinfo.bottom ? bot_q : top_q;
    c_vld = cinfo.bottom || top_vld_q;
    unique case (cinfo.col)
      COL_LEFT: begin
        c_col = cl_q;
        c_vld = c_vld && cl_vld_q;
      end
      COL_MID:   c_col = cm_q;
      COL_RIGHT: c_col = cr_q;
      default:   c_col = cl_q;
    endcase
  end

  // next state and datapath control
  always_comb begin
    state_d     = state_q;
    width_d     = width_q;
    height_d    = height_q;
    row_d       = row_q;
    col_d       = col_q;
    rsum_d      = rsum_q;
    complete_d  = complete_q;
    above_vld_d = above_vld_q;
    top_d       = top_q;
    bot_d       = bot_q;
    top_vld_d   = top_vld_q;
    cl_d        = cl_q;
    cm_d        = cm_q;
    cr_d        = cr_q;
    cl_vld_d    = cl_vld_q;
    k_d         = k_q;
    cv_d        = cv_q;
    acc_d       = acc_q;
    is_query_d  = is_query_q;
    qstat_d     = qstat_q;
    out_valid_d = out_valid_q && out_stall_i;
    ival_d      = ival_q;
    fval_d      = fval_q;
    ostat_d     = ostat_q;
    mem_addr    = addr_of(row_q, col_q);
    mem_we      = 1'b0;
    mem_wdata   = alu_sum[IV_W-1:0];
    alu_a       = '0;
    alu_b       = '0;
    alu_neg     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (operation_i == OP_LOAD) begin
            // restart on a finished image, add pixel, fetch entry above
            row_d       = eff_row;
            col_d       = eff_col;
            rsum_d      = eff_rsum + RSUM_W'(pixel_i);
            complete_d  = 1'b0;
            above_vld_d = (eff_row != '0);
            mem_addr    = addr_of(eff_row - REG_W'(1), eff_col);
            is_query_d  = 1'b0;
            state_d     = ST_LOAD;
          end else begin
            top_d      = REG_W'(start_row_i) - REG_W'(1);
            top_vld_d  = (start_row_i != '0);
            bot_d      = row_end[REG_W-1:0] - REG_W'(1);
            cl_d       = REG_W'(start_col_i) - REG_W'(1);
            cl_vld_d   = (start_col_i != '0);
            cm_d       = cm_sum[REG_W-1:0];
            cr_d       = cr_sum[REG_W-1:0];
            k_d        = '0;
            cv_d       = 1'b0;
            acc_d      = '0;
            is_query_d = 1'b1;
            qstat_d    = chk_stat;
            state_d    = (chk_stat == STATUS_OK) ? ST_QUERY : ST_DONE;
          end
        end else if (cfg_we_i) begin
          unique case (cfg_idx_i)
            REG_IMAGE_WIDTH:  width_d  = clamp_size(cfg_wdata_i, MAX_WIDTH);
            REG_IMAGE_HEIGHT: height_d = clamp_size(cfg_wdata_i, MAX_HEIGHT);
            default: ;
          endcase
          row_d      = '0;
          col_d      = '0;
          rsum_d     = '0;
          complete_d = 1'b0;
        end
      end

      ST_LOAD: begin
        // integral value = entry above + running row sum
        alu_a     = FV_W'(above_vld_q ? rd_q : '0);
        alu_b     = FV_W'(rsum_q);
        acc_d     = alu_sum;
        mem_addr  = addr_of(row_q, col_q);
        mem_we    = 1'b1;
        if ({1'b0, col_q} + (REG_W+1)'(1) >= {1'b0, width_q}) begin
          col_d  = '0;
          rsum_d = '0;
          if ({1'b0, row_q} + (REG_W+1)'(1) >= {1'b0, height_q}) begin
            row_d      = '0;
            complete_d = 1'b1;
          end else begin
            row_d = row_q + REG_W'(1);
          end
        end else begin
          col_d = col_q + REG_W'(1);
        end
        state_d = ST_DONE;
      end

      ST_QUERY: begin
        // read corner k while folding in corner k-1
        mem_addr = addr_of(c_row, c_col);
        cv_d     = c_vld;
        alu_a    = acc_q;
        alu_b    = (cv_q && k_q != '0)
                 ? (pinfo.dbl ? {rd_q, 1'b0} : FV_W'(rd_q)) : '0;
        alu_neg  = pinfo.neg;
        acc_d    = alu_sum;
        k_d      = k_q + CNT_W'(1);
        if (k_q == CNT_W'(NUM_CORNERS)) begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (is_query_q) begin
            ival_d  = '0;
            fval_d  = (qstat_q == STATUS_OK) ? acc_q : '0;
            ostat_d = qstat_q;
          end else begin
            ival_d  = acc_q[IV_W-1:0];
            fval_d  = '0;
            ostat_d = STATUS_OK;
          end
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= clamp_size(REG_W'(REG_RESET), MAX_WIDTH);
      height_q    <= clamp_size(REG_W'(REG_RESET), MAX_HEIGHT);
      row_q       <= '0;
      col_q       <= '0;
      rsum_q      <= '0;
      complete_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      width_q     <= width_d;
      height_q    <= height_d;
      row_q       <= row_d;
      col_q       <= col_d;
      rsum_q      <= rsum_d;
      complete_q  <= complete_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    above_vld_q <= above_vld_d;
    top_q       <= top_d;
    bot_q       <= bot_d;
    top_vld_q   <= top_vld_d;
    cl_q        <= cl_d;
    cm_q        <= cm_d;
    cr_q        <= cr_d;
    cl_vld_q    <= cl_vld_d;
    k_q         <= k_d;
    cv_q        <= cv_d;
    acc_q       <= acc_d;
    is_query_q  <= is_query_d;
    qstat_q     <= qstat_d;
    ival_q      <= ival_d;
    fval_q      <= fval_d;
    ostat_q     <= ostat_d;
  end

  // integral store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_q <= mem[mem_addr];
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign integral_value_o = ival_q;
  assign feature_value_o  = fval_q;
  assign status_o         = ostat_q;

endmodule

/* bench/tb_integral_image_haar_feature.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_integral_image_haar_feature: self-checking bench for the Haar block
// loads images of many sizes, queries windows on them and checks every
// transaction against an integral image rebuilt inside the bench
// ---------------------------------------------------------------------------
module tb_integral_image_haar_feature
  import iihf_pkg::*;
();

  localparam int MAX_W         = DEF_MAX_WIDTH;
  localparam int MAX_H         = DEF_MAX_HEIGHT;
  localparam int RAND_ITEMS    = 1300;     // random transactions after the directed part
  localparam int SETTLE_CYCLES = 12;       // wait after draining, leaves slack for a query in flight
  localparam int CYCLE_LIMIT   = 600000;

  // pixel patterns for a whole image
  typedef enum int {
    FILL_RANDOM,
    FILL_BRIGHT,
    FILL_DARK,
    FILL_LEFT,     // left half of each row full scale, right half black
    FILL_RIGHT     // the mirror image, drives the feature negative
  } fill_e;

  // one input transaction, drain holds it back until all results are in
  typedef struct packed {
    logic              drain;
    logic              op;
    logic [PIX_W-1:0]  pix;
    logic [POS_W-1:0]  srow;
    logic [POS_W-1:0]  scol;
    logic [SIZE_W-1:0] nrows;
    logic [SIZE_W-1:0] ncols;
  } haar_item_t;

  typedef struct packed {
    logic [IV_W-1:0] ival;
    logic [FV_W-1:0] fval;
    logic [ST_W-1:0] status;
  } haar_result_t;

  // dut ports
  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic                   cfg_idx_i   = 1'b0;
  logic [REG_W-1:0]       cfg_wdata_i = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic                   operation_i = 1'b0;
  logic [PIX_W-1:0]       pixel_i     = '0;
  logic [POS_W-1:0]       start_row_i = '0;
  logic [POS_W-1:0]       start_col_i = '0;
  logic [SIZE_W-1:0]      num_rows_i  = '0;
  logic [SIZE_W-1:0]      num_cols_i  = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [IV_W-1:0]        integral_value_o;
  logic signed [FV_W-1:0] feature_value_o;
  logic [ST_W-1:0]        status_o;

  integral_image_haar_feature uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .pixel_i         (pixel_i),
    .start_row_i     (start_row_i),
    .start_col_i     (start_col_i),
    .num_rows_i      (num_rows_i),
    .num_cols_i      (num_cols_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .integral_value_o(integral_value_o),
    .feature_value_o (feature_value_o),
    .status_o        (status_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // integral image predictor
  // ---------------------------------------------------------------------------
  logic [IV_W-1:0]   sat_mem [MAX_W*MAX_H];   // summed-area table, row*MAX_W+col
  int                img_w = MAX_W;           // effective sizes after clamping
  int                img_h = MAX_H;
  logic [RSUM_W-1:0] run_sum = '0;
  int                at_row = 0;
  int                at_col = 0;
  bit                img_full = 1'b0;

  // register value to size in use: zero means one, too large means the maximum
  function automatic int fit_size(logic [REG_W-1:0] raw, int maxv);
    if (raw == '0) return 1;
    if (int'(raw) > maxv) return maxv;
    return int'(raw);
  endfunction

  function automatic void restart_image();
    run_sum  = '0;
    at_row   = 0;
    at_col   = 0;
    img_full = 1'b0;
  endfunction

  // corners above row 0 or left of column 0 read as zero
  function automatic longint sat_corner(int r, int c);
    if (r < 0 || c < 0) return 0;
    return longint'(sat_mem[r*MAX_W + c]);
  endfunction

  function automatic haar_result_t predict_haar(haar_item_t it);
    haar_result_t    res;
    logic [IV_W-1:0] above;
    int              top, bot, cl, cm, cr;
    longint          diff;
    res        = '0;
    res.status = STATUS_OK;
    if (it.op == OP_LOAD) begin
      // a load after a finished image starts the next one
      if (img_full) restart_image();
      run_sum  = run_sum + RSUM_W'(it.pix);
      above    = (at_row > 0) ? sat_mem[(at_row - 1)*MAX_W + at_col] : '0;
      res.ival = above + IV_W'(run_sum);
      sat_mem[at_row*MAX_W + at_col] = res.ival;
      if (at_col + 1 >= img_w) begin
        at_col  = 0;
        run_sum = '0;
        if (at_row + 1 >= img_h) begin
          at_row   = 0;
          img_full = 1'b1;
        end else begin
          at_row++;
        end
      end else begin
        at_col++;
      end
    end else if (int'(it.srow) + int'(it.nrows) > img_h ||
                 int'(it.scol) + int'(it.ncols) > img_w) begin
      res.status = STATUS_OUT_BOUNDS;
    end else if (it.nrows == '0 || it.ncols == '0) begin
      res.status = STATUS_ZERO_SIZE;
    end else if (it.ncols[0]) begin
      res.status = STATUS_ODD_WIDTH;
    end else if (!img_full) begin
      res.status = STATUS_INCOMPLETE;
    end else begin
      top  = int'(it.srow) - 1;
      bot  = top + int'(it.nrows);
      cl   = int'(it.scol) - 1;
      cm   = cl + int'(it.ncols) / 2;
      cr   = cl + int'(it.ncols);
      // left half minus right half: +a -2b +c -d +2e -f
      diff = sat_corner(top, cl) - 2 * sat_corner(top, cm) + sat_corner(top, cr)
           - sat_corner(bot, cl) + 2 * sat_corner(bot, cm) - sat_corner(bot, cr);
      res.fval = diff[FV_W-1:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus queues
  // ---------------------------------------------------------------------------
  haar_item_t   haar_items_q[$];       // transactions waiting for the driver
  haar_result_t expected_haar_q[$];    // predicted results, oldest first
  int           stim_count = 0;
  bit           drain_next = 1'b0;     // next pushed transaction waits for a drained block
  int           fail_cnt   = 0;
  int unsigned  cycle_cnt  = 0;

  task automatic push_load(logic [PIX_W-1:0] pix);
    haar_item_t it;
    it.drain = drain_next;
    it.op    = OP_LOAD;
    it.pix   = pix;
    // query fields are don't-care on a load, keep them moving
    it.srow  = POS_W'($urandom);
    it.scol  = POS_W'($urandom);
    it.nrows = SIZE_W'($urandom);
    it.ncols = SIZE_W'($urandom);
    drain_next = 1'b0;
    haar_items_q.push_back(it);
    stim_count++;
  endtask

  task automatic push_query(int sr, int sc, int nr, int nc);
    haar_item_t it;
    it.drain = drain_next;
    it.op    = OP_QUERY;
    it.pix   = PIX_W'($urandom);
    it.srow  = POS_W'(sr);
    it.scol  = POS_W'(sc);
    it.nrows = SIZE_W'(nr);
    it.ncols = SIZE_W'(nc);
    drain_next = 1'b0;
    haar_items_q.push_back(it);
    stim_count++;
  endtask

  // half the time near the image edges so every check fires, else anything at all
  task automatic push_stray_query();
    int sr, sc, nr, nc;
    if ($urandom_range(0, 1) == 0) begin
      sr = $urandom_range(0, img_h - 1);
      sc = $urandom_range(0, img_w - 1);
      nr = $urandom_range(0, img_h - sr + 1);
      nc = $urandom_range(0, img_w - sc + 1);
    end else begin
      sr = $urandom_range(0, 255);
      sc = $urandom_range(0, 255);
      nr = $urandom_range(0, 511);
      nc = $urandom_range(0, 511);
    end
    push_query(sr, sc, nr, nc);
  endtask

  // a window that passes every check once the image is complete, or a stray query if the image is under two columns
  task automatic push_window_query();
    int sr, sc, nr, nc;
    if (img_w < 2) begin
      push_stray_query();
    end else begin
      nr = $urandom_range(1, img_h);
      sr = $urandom_range(0, img_h - nr);
      nc = 2 * $urandom_range(1, img_w / 2);
      sc = $urandom_range(0, img_w - nc);
      push_query(sr, sc, nr, nc);
    end
  endtask

  task automatic load_pixels(fill_e fill, int count);
    int               col;
    logic [PIX_W-1:0] pix;
    for (int k = 0; k < count; k++) begin
      col = k % img_w;
      case (fill)
        FILL_BRIGHT: pix = {PIX_W{1'b1}};
        FILL_DARK:   pix = '0;
        FILL_LEFT:   pix = (col < img_w / 2) ? {PIX_W{1'b1}} : {PIX_W{1'b0}};
        FILL_RIGHT:  pix = (col >= img_w / 2) ? {PIX_W{1'b1}} : {PIX_W{1'b0}};
        default:     pix = PIX_W'($urandom);
      endcase
      push_load(pix);
      // the odd query in the middle of a load sees an incomplete image
      if ($urandom_range(0, 11) == 0) push_stray_query();
    end
  endtask

  // sampled on the falling edge so that no posedge update is half done
  task automatic wait_drained();
    do @(negedge clk_i);
    while (haar_items_q.size() != 0 || in_valid_i || expected_haar_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register writes only land on an idle block; each one restarts loading
  task automatic write_size(logic idx, logic [REG_W-1:0] raw);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= raw;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) begin
      img_w = fit_size(raw, MAX_W);
    end else begin
      img_h = fit_size(raw, MAX_H);
    end
    restart_image();
  endtask

  // one image size: full load, queries, maybe a reload and a partial image
  task automatic run_phase(logic [REG_W-1:0] raw_w, logic [REG_W-1:0] raw_h, int nq);
    int npix;
    if ($urandom_range(0, 1) == 0) begin
      write_size(REG_IMAGE_WIDTH, raw_w);
      write_size(REG_IMAGE_HEIGHT, raw_h);
    end else begin
      write_size(REG_IMAGE_HEIGHT, raw_h);
      write_size(REG_IMAGE_WIDTH, raw_w);
    end
    npix = img_w * img_h;
    load_pixels(fill_e'($urandom_range(0, 4)), npix);
    drain_next = ($urandom_range(0, 3) == 0);
    repeat (nq) begin
      if ($urandom_range(0, 4) != 0) push_window_query();
      else push_stray_query();
    end
    // loading on top of a finished image starts a fresh one
    if ($urandom_range(0, 2) == 0) begin
      load_pixels(fill_e'($urandom_range(0, 4)), npix);
      repeat (nq / 2 + 1) push_window_query();
    end
    // stop part way so queries report the incomplete image
    if (npix > 1 && $urandom_range(0, 3) == 0) begin
      load_pixels(fill_e'($urandom_range(0, 4)), $urandom_range(1, npix - 1));
      repeat (3) push_window_query();
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: one transaction at a time from the queue, random gaps between them
  // ---------------------------------------------------------------------------
  haar_item_t in_flight;
  int         send_gap   = 0;
  bit         send_burst = 1'b0;   // stretches with no gaps at all

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && in_stall_o)) begin
      // the transaction on the port was just taken
      if (in_valid_i) begin
        expected_haar_q.push_back(predict_haar(in_flight));
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (haar_items_q.size() != 0 &&
                   !(haar_items_q[0].drain && expected_haar_q.size() != 0)) begin
        in_flight    = haar_items_q.pop_front();
        operation_i <= in_flight.op;
        pixel_i     <= in_flight.pix;
        start_row_i <= in_flight.srow;
        start_col_i <= in_flight.scol;
        num_rows_i  <= in_flight.nrows;
        num_cols_i  <= in_flight.ncols;
        in_valid_i  <= 1'b1;
        if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 4);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random stall after each result, compare against the oldest prediction
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  bit recv_burst = 1'b0;

  task automatic check_result();
    haar_result_t want;
    if (expected_haar_q.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= 10) begin
        $display("unexpected result: iv %0d fv %0d status %0d",
                 integral_value_o, feature_value_o, status_o);
      end
    end else begin
      want = expected_haar_q.pop_front();
      if (integral_value_o !== want.ival || feature_value_o !== want.fval ||
          status_o !== want.status) begin
        fail_cnt++;
        if (fail_cnt <= 10) begin
          $display("result differs: exp iv %0d fv %0d status %0d, got iv %0d fv %0d status %0d",
                   want.ival, $signed(want.fval), want.status,
                   integral_value_o, feature_value_o, status_o);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        check_result();
        if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
        stall_left = recv_burst ? 0 : $urandom_range(0, 4);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("integral_image_haar_feature: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset size 256x256, nothing loaded: every check in its priority order
    push_query(0, 0, 2, 2);         // fine window, image incomplete
    push_query(255, 0, 2, 2);       // runs off the bottom
    push_query(0, 255, 1, 2);       // runs off the right edge
    push_query(0, 0, 0, 2);         // zero height
    push_query(0, 0, 256, 256);     // largest window, still incomplete
    push_query(0, 0, 3, 3);         // odd width
    push_query(0, 0, 0, 3);         // zero size wins over odd width
    push_query(255, 0, 511, 0);     // bounds win over zero size
    push_load(8'hFF);
    push_load(8'h00);

    // tiny 2x2 image, queries touching the zero corners and row 0
    write_size(REG_IMAGE_WIDTH, REG_W'(2));
    write_size(REG_IMAGE_HEIGHT, REG_W'(2));
    push_load(8'hFF);
    push_load(8'h00);
    push_load(8'hFF);
    push_load(8'hFF);
    drain_next = 1'b1;              // hold off until the loads are all back
    push_query(0, 0, 2, 2);
    push_query(1, 0, 1, 2);
    push_query(0, 0, 1, 2);
    push_query(0, 0, 1, 1);         // odd width on a complete image
    push_load(8'h07);               // starts a new image
    push_query(0, 0, 2, 2);         // which is incomplete again

    // extremes: full width, full height (clamped), zero registers clamp to one
    stim_count = 0;
    run_phase(REG_W'(511), REG_W'(1), 12);
    run_phase(REG_W'(2), REG_W'(300), 12);
    run_phase(REG_W'(0), REG_W'(0), 4);

    // mostly small images so that many complete ones fit in the run
    while (stim_count < RAND_ITEMS) begin
      run_phase(($urandom_range(0, 7) == 0) ? REG_W'($urandom_range(17, 40))
                                            : REG_W'($urandom_range(1, 16)),
                REG_W'($urandom_range(1, 10)), $urandom_range(5, 20));
    end

    wait_drained();
    if (fail_cnt == 0 && expected_haar_q.size() == 0) begin
      $display("integral_image_haar_feature: match");
    end else begin
      $display("integral_image_haar_feature: mismatch");
    end
    $finish;
  end

endmodule

/* integral_image_haar_feature.f */
src/iihf_pkg.sv
src/integral_image_haar_feature.sv
bench/tb_integral_image_haar_feature.sv
